>>> design/rda_pkg.sv
// ----------------------------------------------------------------------------
// rda_pkg
// shared types and constants of the radix digit analyzer
// ----------------------------------------------------------------------------
package rda_pkg;

  localparam int RADIX_W   = 16;
  localparam int POS_W     = 5;
  localparam int SUM_W     = 31;
  localparam int COUNT_W   = 5;
  // quotient bits retired by the divider in one cycle
  localparam int DIV_BITS  = 4;

  localparam logic [RADIX_W-1:0] RESET_RADIX = 16'd10;
  localparam logic [RADIX_W-1:0] MIN_RADIX   = 16'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture a new word, clear accumulators
    logic div_init;  // load divider with the running value
    logic div_step;  // one divider iteration
    logic accum;     // fold the finished digit into the results
    logic finish;    // register results and pulse done
  } rda_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic value_zero;
  } rda_stat_t;

endpackage

>>> design/radix_digit_analyzer_unit.sv
// ----------------------------------------------------------------------------
// radix_digit_analyzer_unit
// splits a word into digits of a configurable radix and reports digit stats
// ----------------------------------------------------------------------------
// A word is taken when start is high while busy is low; busy then stays high
// until the result is out. Digits come from repeated division by the radix in
// one shared divider that retires four quotient bits per cycle while it
// steps; each digit takes a check, the divider steps and an accumulate, and
// each word ends in a finish state. Results appear for exactly one cycle with
// done high and cannot be stalled; the result ports hold their value until
// the next result. The radix is written through cfg_valid (always ready);
// the user must write it only while the unit is idle, which the unit does
// not enforce itself. Writes of zero or one are ignored.
module radix_digit_analyzer_unit #(
  parameter int VALUE_BITS = 31
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [VALUE_BITS-1:0]        value,
  input  logic [rda_pkg::POS_W-1:0]    digit_position,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rda_pkg::RADIX_W-1:0]  radix,
  output logic                         done,
  output logic [rda_pkg::RADIX_W-1:0]  digit,
  output logic [rda_pkg::SUM_W-1:0]    digit_sum,
  output logic [rda_pkg::COUNT_W-1:0]  nonzero_count,
  output logic [rda_pkg::COUNT_W-1:0]  digit_count
);

  localparam int STEPS = (VALUE_BITS + rda_pkg::DIV_BITS - 1) / rda_pkg::DIV_BITS;
  localparam int DIV_W = STEPS * rda_pkg::DIV_BITS;

  rda_pkg::rda_cmd_t  cmd;
  rda_pkg::rda_stat_t stat;

  assign cfg_ready = 1'b1;

  rda_ctrl #(
    .STEPS (STEPS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rda_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_W      (DIV_W)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .radix          (radix),
    .value          (value),
    .digit_position (digit_position),
    .cmd            (cmd),
    .stat           (stat),
    .done           (done),
    .digit          (digit),
    .digit_sum      (digit_sum),
    .nonzero_count  (nonzero_count),
    .digit_count    (digit_count)
  );

endmodule

>>> design/rda_ctrl.sv
// ----------------------------------------------------------------------------
// rda_ctrl
// sequencer: walks one word through repeated division by the radix
// ----------------------------------------------------------------------------
module rda_ctrl #(
  parameter int STEPS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rda_pkg::rda_stat_t stat,
  output rda_pkg::rda_cmd_t  cmd
);

  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_DIV    = 5'b00100,
    S_ACC    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              last_step;

  assign last_step = (step == STEP_W'(STEPS - 1));
  assign busy      = (state != S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.value_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          step_next    = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (last_step) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        state_next = S_CHECK;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

>>> design/rda_datapath.sv
// ----------------------------------------------------------------------------
// rda_datapath
// radix register, shared radix-16 restoring divider and digit accumulators
// ----------------------------------------------------------------------------
module rda_datapath #(
  parameter int VALUE_BITS = 31,
  parameter int DIV_W      = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [rda_pkg::RADIX_W-1:0]  radix,
  input  logic [VALUE_BITS-1:0]        value,
  input  logic [rda_pkg::POS_W-1:0]    digit_position,
  input  rda_pkg::rda_cmd_t            cmd,
  output rda_pkg::rda_stat_t           stat,
  output logic                         done,
  output logic [rda_pkg::RADIX_W-1:0]  digit,
  output logic [rda_pkg::SUM_W-1:0]    digit_sum,
  output logic [rda_pkg::COUNT_W-1:0]  nonzero_count,
  output logic [rda_pkg::COUNT_W-1:0]  digit_count
);

  localparam int CNT_RAW = $clog2(VALUE_BITS + 1);
  localparam int CNT_W   = (CNT_RAW > rda_pkg::POS_W) ? CNT_RAW : rda_pkg::POS_W;
  localparam int RW      = rda_pkg::RADIX_W;

  logic [RW-1:0]               base;
  logic [VALUE_BITS-1:0]       t;
  logic [rda_pkg::POS_W-1:0]   pos;
  logic [DIV_W-1:0]            div_sr;
  logic [DIV_W-1:0]            div_sr_next;
  logic [RW-1:0]               rem;
  logic [RW-1:0]               rem_next;
  logic [rda_pkg::SUM_W-1:0]   sum;
  logic [CNT_W-1:0]            nz;
  logic [CNT_W-1:0]            cnt;
  logic [RW-1:0]               dig;

  assign stat.value_zero = (t == '0);

  // DIV_BITS restoring division steps, msb first
  always_comb begin
    logic [RW:0]      r;
    logic [DIV_W-1:0] s;
    r = {1'b0, rem};
    s = div_sr;
    for (int i = 0; i < rda_pkg::DIV_BITS; i++) begin
      r = {r[RW-1:0], s[DIV_W-1]};
      s = {s[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, base}) begin
        r    = r - {1'b0, base};
        s[0] = 1'b1;
      end
    end
    div_sr_next = s;
    rem_next    = r[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= rda_pkg::RESET_RADIX;
    end else if (cfg_valid && (radix >= rda_pkg::MIN_RADIX)) begin
      base <= radix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t   <= value;
      pos <= digit_position;
      sum <= '0;
      nz  <= '0;
      cnt <= '0;
      dig <= '0;
    end
    if (cmd.div_init) begin
      div_sr <= DIV_W'(t);
      rem    <= '0;
    end
    if (cmd.div_step) begin
      div_sr <= div_sr_next;
      rem    <= rem_next;
    end
    if (cmd.accum) begin
      t   <= div_sr[VALUE_BITS-1:0];
      sum <= sum + rda_pkg::SUM_W'(rem);
      if (rem != '0) begin
        nz <= nz + CNT_W'(1);
      end
      if (cnt == CNT_W'(pos)) begin
        dig <= rem;
      end
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.finish) begin
      digit         <= dig;
      digit_sum     <= sum;
      nonzero_count <= nz[rda_pkg::COUNT_W-1:0];
      digit_count   <= cnt[rda_pkg::COUNT_W-1:0];
    end
  end

endmodule

>>> tb/tb_radix_digit_analyzer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_digit_analyzer_unit
// self-checking bench for the radix digit analyzer
// ----------------------------------------------------------------------------
// Words go in through the start/busy handshake. Each accepted word is run
// through a local digit-splitting predictor using the radix that the bench
// believes is loaded, and the expected stats are queued. Every done pulse is
// compared field by field against the oldest queued entry. A directed part
// covers the default radix, ignored radix writes and the extreme radixes; a
// random part then sweeps several radix settings with random idle gaps.
// ----------------------------------------------------------------------------
module tb_radix_digit_analyzer_unit;

  localparam int VALUE_W         = 31;
  localparam int MAX_CYCLES      = 3_000_000;
  localparam int IDLE_PCT        = 23;
  localparam int WORDS_PER_PHASE = 140;
  localparam int NUM_PHASES      = 10;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef struct packed {
    logic [rda_pkg::RADIX_W-1:0] digit;
    logic [rda_pkg::SUM_W-1:0]   digit_sum;
    logic [rda_pkg::COUNT_W-1:0] nonzero_count;
    logic [rda_pkg::COUNT_W-1:0] digit_count;
  } digit_stats_t;

  logic                          clk            = 1'b0;
  logic                          rst            = 1'b1;
  logic                          start          = 1'b0;
  logic [VALUE_W-1:0]            value          = '0;
  logic [rda_pkg::POS_W-1:0]     digit_position = '0;
  logic                          cfg_valid      = 1'b0;
  logic [rda_pkg::RADIX_W-1:0]   radix          = rda_pkg::RESET_RADIX;
  logic                          busy;
  logic                          cfg_ready;
  logic                          done;
  logic [rda_pkg::RADIX_W-1:0]   digit;
  logic [rda_pkg::SUM_W-1:0]     digit_sum;
  logic [rda_pkg::COUNT_W-1:0]   nonzero_count;
  logic [rda_pkg::COUNT_W-1:0]   digit_count;

  // radix the unit should be using right now
  logic [rda_pkg::RADIX_W-1:0]   loaded_radix = rda_pkg::RESET_RADIX;
  digit_stats_t                  pending_stats[$];
  int                            errors = 0;
  int                            cycles = 0;
  bit                            steady = 1'b0;

  radix_digit_analyzer_unit #(
    .VALUE_BITS(VALUE_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .digit_position(digit_position),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .radix         (radix),
    .done          (done),
    .digit         (digit),
    .digit_sum     (digit_sum),
    .nonzero_count (nonzero_count),
    .digit_count   (digit_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic digit_stats_t digit_stats(input logic [VALUE_W-1:0] v,
                                               input logic [rda_pkg::POS_W-1:0] p,
                                               input logic [rda_pkg::RADIX_W-1:0] b);
    digit_stats_t    s;
    longint unsigned rest;
    longint unsigned quo;
    longint unsigned d;
    longint unsigned sum;
    int unsigned     n;
    int unsigned     nz;
    s    = '0;
    rest = 64'(v);
    sum  = 0;
    n    = 0;
    nz   = 0;
    while (rest != 0) begin
      quo = rest / 64'(b);
      d   = rest - quo * 64'(b);
      if (n == 32'(p)) s.digit = d[rda_pkg::RADIX_W-1:0];
      sum += d;
      if (d != 0) nz++;
      n++;
      rest = quo;
    end
    s.digit_sum     = sum[rda_pkg::SUM_W-1:0];
    s.nonzero_count = nz[rda_pkg::COUNT_W-1:0];
    s.digit_count   = n[rda_pkg::COUNT_W-1:0];
    return s;
  endfunction

  // full random, shortened, small, or a power of the radix (and one below it)
  function automatic logic [VALUE_W-1:0] random_value(
      input logic [rda_pkg::RADIX_W-1:0] b);
    longint unsigned pw;
    int              k;
    case ($urandom_range(3))
      0: return VALUE_W'($urandom);
      1: return VALUE_W'($urandom >> $urandom_range(31));
      2: return VALUE_W'($urandom_range(999));
      default: begin
        pw = 1;
        k  = $urandom_range(31, 1);
        repeat (k) if (pw * b <= VALUE_MAX) pw *= b;
        return VALUE_W'(pw - 64'($urandom_range(1)));
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    digit_stats_t want;
    if (!rst && done === 1'b1) begin
      if (pending_stats.size() == 0) begin
        $error("result word with no word pending");
        errors++;
      end else begin
        want = pending_stats.pop_front();
        if (digit !== want.digit) begin
          $error("digit: expected %0d, got %0d", want.digit, digit);
          errors++;
        end
        if (digit_sum !== want.digit_sum) begin
          $error("digit_sum: expected %0d, got %0d", want.digit_sum, digit_sum);
          errors++;
        end
        if (nonzero_count !== want.nonzero_count) begin
          $error("nonzero_count: expected %0d, got %0d", want.nonzero_count,
                 nonzero_count);
          errors++;
        end
        if (digit_count !== want.digit_count) begin
          $error("digit_count: expected %0d, got %0d", want.digit_count, digit_count);
          errors++;
        end
      end
    end
  end

  // start stays high after acceptance so back-to-back words need no toggle
  task automatic send_word(input logic [VALUE_W-1:0] v,
                           input logic [rda_pkg::POS_W-1:0] p);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    value          <= v;
    digit_position <= p;
    do @(posedge clk); while (busy !== 1'b0);
    pending_stats.push_back(digit_stats(v, p, loaded_radix));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_stats.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // last clear means no further write follows directly
  task automatic write_radix(input logic [rda_pkg::RADIX_W-1:0] r,
                             input bit last = 1'b1);
    wait_drained();
    cfg_valid <= 1'b1;
    radix     <= r;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (r >= rda_pkg::MIN_RADIX) loaded_radix = r;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic test_default_radix();
    send_word('0, 5'd0);
    send_word('0, 5'd31);
    send_word(VALUE_MAX, 5'd0);
    send_word(VALUE_MAX, 5'd9);
    send_word(VALUE_MAX, 5'd10);
    send_word(VALUE_MAX, 5'd31);
    send_word(31'd1234567890, 5'd4);
    send_word(31'd999999999, 5'd8);
  endtask

  // zero and one must leave the radix at ten
  task automatic test_ignored_writes();
    write_radix(16'd0, 1'b0);
    write_radix(16'd1);
    send_word(VALUE_MAX, 5'd9);
    send_word(31'd5, 5'd0);
  endtask

  task automatic test_radix_extremes();
    write_radix(16'd2);
    send_word(VALUE_MAX, 5'd30);
    send_word(VALUE_MAX, 5'd31);
    send_word(31'd1, 5'd0);
    send_word(31'h4000_0000, 5'd30);
    write_radix(16'hFFFF);
    send_word(31'd65534, 5'd0);
    send_word(VALUE_MAX, 5'd1);
    send_word(VALUE_MAX, 5'd2);
    send_word(31'd65535, 5'd1);
    write_radix(16'd1);
    send_word(31'd65535, 5'd0);
  endtask

  task automatic test_random_words();
    logic [rda_pkg::RADIX_W-1:0] bases[NUM_PHASES];
    logic [VALUE_W-1:0]          v;
    logic [rda_pkg::POS_W-1:0]   p;
    digit_stats_t                s;
    bases = '{16'd2, 16'd3, 16'd7, 16'd10, 16'd16, 16'd255, 16'd256, 16'hFFFF,
              16'd0, 16'd0};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph >= 8) bases[ph] = rda_pkg::RADIX_W'($urandom_range(65535));
      write_radix(bases[ph]);
      // one phase runs with no sender gaps at all
      steady = (ph == 3);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        v = random_value(loaded_radix);
        if ($urandom_range(1)) begin
          p = rda_pkg::POS_W'($urandom_range(31));
        end else begin
          s = digit_stats(v, '0, loaded_radix);
          p = rda_pkg::POS_W'($urandom_range(32'(s.digit_count)));
        end
        send_word(v, p);
        if ($urandom_range(199) == 0) wait_drained();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_default_radix();
    test_ignored_writes();
    test_radix_extremes();
    test_random_words();
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
